### hdl/linear_creep_force_top_defines.svh
// Assertion macros shared by the linear creep force block.
`ifndef LINEAR_CREEP_FORCE_TOP_DEFINES_SVH
`define LINEAR_CREEP_FORCE_TOP_DEFINES_SVH

// Checks that an antecedent implies a consequent in the same cycle.
`define LCF_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Checks that an antecedent implies a consequent in the next cycle.
`define LCF_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/lcf_pkg.sv
`default_nettype none
package lcf_pkg;
	localparam int FRAC_BITS_DEF = 24;
	localparam int SLIP_W = 32;
	localparam int FORCE_W = 64;
	localparam int SPEED_W = 32;
	localparam int NUM_LANES = 3;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 63;

	localparam logic [CFG_IDX_W-1:0] REG_SEMI_LONG = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SEMI_LAT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SHEAR     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_C11       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_C22       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_C23       = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_C33       = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED = 3'd7;

	localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

	typedef struct packed {
		logic signed [SLIP_W-1:0] slip_long;
		logic signed [SLIP_W-1:0] slip_lat;
		logic signed [SLIP_W-1:0] slip_spin;
		logic signed [SLIP_W-1:0] ref_speed;
	} in_item_t;

	typedef struct packed {
		logic signed [FORCE_W-1:0] force_long;
		logic signed [FORCE_W-1:0] force_lat;
		logic signed [FORCE_W-1:0] spin_moment;
		logic [SPEED_W-1:0] used_speed;
	} out_item_t;

	// Sign and magnitude form to a saturated signed 64-bit value.
	function automatic logic signed [63:0] from_mag(input logic neg, input logic [63:0] mag);
		logic signed [63:0] r;
		if (!neg) r = mag[63] ? S64_MAX : $signed(mag);
		else if (mag[63]) r = S64_MIN;
		else r = -$signed(mag);
		return r;
	endfunction

	function automatic logic [63:0] mag_of(input logic signed [63:0] x);
		return x[63] ? 64'(-x) : 64'(x);
	endfunction

	function automatic logic signed [63:0] sat_add(input logic signed [63:0] x,
			input logic signed [63:0] y);
		logic signed [63:0] s;
		s = x + y;
		if (!x[63] && !y[63] && s[63]) s = S64_MAX;
		else if (x[63] && y[63] && !s[63]) s = S64_MIN;
		return s;
	endfunction

	function automatic logic signed [63:0] sat_neg(input logic signed [63:0] x);
		return (x == S64_MIN) ? S64_MAX : -x;
	endfunction
endpackage
`default_nettype wire

### hdl/lcf_stream_if.sv
`default_nettype none
interface lcf_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### hdl/linear_creep_force_top.sv
// Pipeline: 32+FRAC_BITS divider stages, two multiply levels, one merge
// register and four pad registers, the last of which is the output register.
// Throughput: one item per cycle; the whole pipeline advances together and
// holds while the output register is full and not taken.
// Reset: asynchronous, active low; clears valid flags and restores configuration registers.
// The derived square root is recomputed after each write to a or b.
`default_nettype none
module linear_creep_force_top #(
	parameter int FRAC_BITS = lcf_pkg::FRAC_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	lcf_stream_if.sink                          in_ch,
	lcf_stream_if.source                        out_ch,
	input  wire logic                           cfg_we,
	input  wire logic [lcf_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [lcf_pkg::CFG_DATA_W-1:0] cfg_data
);
	import lcf_pkg::*;
	`include "linear_creep_force_top_defines.svh"

	localparam int DIV_LAT = 32 + FRAC_BITS;
	localparam int LAT = DIV_LAT + 11;

	logic [62:0] shear; logic [31:0] c11, c22, c23, c33, mins;
	logic [63:0] ab, rt;
	lcf_cfg #(.FRAC_BITS(FRAC_BITS)) u_cfg (.clk, .arst_n, .cfg_we, .cfg_idx, .cfg_data,
		.shear_q(shear), .c11_q(c11), .c22_q(c22), .c23_q(c23), .c33_q(c33),
		.min_q(mins), .ab_q(ab), .rt_q(rt));

	in_item_t  din;
	logic [31:0] spd;
	logic        en, full_q, in_xfer;
	logic [LAT-1:0] vld_q;
	logic [31:0] spd_p [LAT+1];
	logic        zero_p [LAT+1];

	assign din = in_ch.data;
	always_comb begin
		spd = din.ref_speed[31] ? 32'(-din.ref_speed) : 32'(din.ref_speed);
		if (spd != '0 && spd <= mins) spd = mins;
	end
	// The pipeline advances unless a finished result still waits.
	assign en = !(full_q && !out_ch.ready) || !vld_q[LAT-1];
	assign in_ch.ready = en;
	assign in_xfer = in_ch.valid && en;

	assign spd_p[0] = spd;
	assign zero_p[0] = (din.ref_speed == '0);
	for (genvar i = 0; i < LAT; i++) begin : g_side
		always_ff @(posedge clk) if (en) begin
			spd_p[i+1] <= spd_p[i];
			zero_p[i+1] <= zero_p[i];
		end
	end

	// Three creepage lanes.
	logic signed [63:0] cx, cy, cp;
	lcf_divlane #(.FRAC_BITS(FRAC_BITS)) u_dx (.clk, .en, .slip(din.slip_long),
		.divisor(spd), .creep(cx));
	lcf_divlane #(.FRAC_BITS(FRAC_BITS)) u_dy (.clk, .en, .slip(din.slip_lat),
		.divisor(spd), .creep(cy));
	lcf_divlane #(.FRAC_BITS(FRAC_BITS)) u_dp (.clk, .en, .slip(din.slip_spin),
		.divisor(spd), .creep(cp));

	// Config products: the user, not the block, keeps them settled while items flow.
	logic signed [63:0] gab, k23, k33;
	lcf_qmul #(.FRAC_BITS(FRAC_BITS)) u_gab (.clk, .en(1'b1), .a($signed({1'b0, shear})),
		.b($signed(ab)), .p(gab));
	lcf_qmul #(.FRAC_BITS(FRAC_BITS)) u_k23 (.clk, .en(1'b1), .a($signed(rt)),
		.b($signed(64'(c23))), .p(k23));
	lcf_qmul #(.FRAC_BITS(FRAC_BITS)) u_k33 (.clk, .en(1'b1), .a($signed(ab)),
		.b($signed(64'(c33))), .p(k33));

	// Level 1: lane products.
	logic signed [63:0] m11, m22, m23p, m23y, m33p;
	lcf_qmul #(.FRAC_BITS(FRAC_BITS)) u_m11 (.clk, .en, .a($signed(64'(c11))), .b(cx), .p(m11));
	lcf_qmul #(.FRAC_BITS(FRAC_BITS)) u_m22 (.clk, .en, .a($signed(64'(c22))), .b(cy), .p(m22));
	lcf_qmul #(.FRAC_BITS(FRAC_BITS)) u_m2p (.clk, .en, .a(k23), .b(cp), .p(m23p));
	lcf_qmul #(.FRAC_BITS(FRAC_BITS)) u_m2y (.clk, .en, .a(k23), .b(cy), .p(m23y));
	lcf_qmul #(.FRAC_BITS(FRAC_BITS)) u_m3p (.clk, .en, .a(k33), .b(cp), .p(m33p));

	// Merge stage: sums registered, then scaled by G*ab.
	logic signed [63:0] fx_s1, fy_s1, mz_s1;
	always_ff @(posedge clk) if (en) begin
		fx_s1 <= m11;
		fy_s1 <= sat_add(m22, m23p);
		mz_s1 <= sat_add(sat_neg(m23y), m33p);
	end
	logic signed [63:0] ox, oy, oz;
	lcf_qmul #(.FRAC_BITS(FRAC_BITS)) u_ox (.clk, .en, .a(gab), .b(fx_s1), .p(ox));
	lcf_qmul #(.FRAC_BITS(FRAC_BITS)) u_oy (.clk, .en, .a(gab), .b(fy_s1), .p(oy));
	lcf_qmul #(.FRAC_BITS(FRAC_BITS)) u_oz (.clk, .en, .a(gab), .b(mz_s1), .p(oz));
	// Pad stages so the side band matches LAT (divider, 3, 1, 3, 4 = DIV_LAT+11).
	logic signed [63:0] ox_p [5], oy_p [5], oz_p [5];
	assign ox_p[0] = ox; assign oy_p[0] = oy; assign oz_p[0] = oz;
	for (genvar j = 0; j < 4; j++) begin : g_pad
		always_ff @(posedge clk) if (en) begin
			ox_p[j+1] <= ox_p[j]; oy_p[j+1] <= oy_p[j]; oz_p[j+1] <= oz_p[j];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[LAT-2:0], in_xfer};
	end

	// The last pipeline stage is the output register itself.
	out_item_t res;
	always_comb begin
		res.force_long = zero_p[LAT] ? '0 : sat_neg(ox_p[4]);
		res.force_lat = zero_p[LAT] ? '0 : sat_neg(oy_p[4]);
		res.spin_moment = zero_p[LAT] ? '0 : sat_neg(oz_p[4]);
		res.used_speed = spd_p[LAT];
	end
	assign full_q = vld_q[LAT-1];
	assign out_ch.valid = full_q;
	assign out_ch.data = res;

	`LCF_ASSERT_IMP(a_stall_blocks_in, clk, arst_n, out_ch.valid && !out_ch.ready, !in_ch.ready,
		"input taken while output stalled")
	`LCF_ASSERT_NEXT(a_hold_valid, clk, arst_n, out_ch.valid && !out_ch.ready, out_ch.valid,
		"result lost during stall")
	`LCF_ASSERT_IMP(a_zero_speed, clk, arst_n, out_ch.valid && res.used_speed == '0,
		res.force_long == '0 && res.force_lat == '0, "nonzero force at zero speed")
endmodule
`default_nettype wire

### hdl/lcf_qmul.sv
`default_nettype none
// Pipelined signed fixed-point multiply: 64x64 magnitudes cut into four
// 32x32 partial products, summed in a second stage, shifted and saturated
// in a third. One operation per cycle while en is high.
module lcf_qmul #(
	parameter int FRAC_BITS = lcf_pkg::FRAC_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic signed [63:0] a,
	input  wire logic signed [63:0] b,
	output logic signed [63:0]      p
);
	import lcf_pkg::*;
	logic [63:0] ll_s1, lh_s1, hl_s1, hh_s1;
	logic neg_s1, neg_s2;
	logic [127:0] prod_s2;
	logic [63:0] ma, mb;
	logic [127:0] sh;

	always_comb begin
		ma = mag_of(a);
		mb = mag_of(b);
	end

	always_comb sh = prod_s2 >> FRAC_BITS;

	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1 <= ma[31:0] * mb[31:0];
			lh_s1 <= ma[31:0] * mb[63:32];
			hl_s1 <= ma[63:32] * mb[31:0];
			hh_s1 <= ma[63:32] * mb[63:32];
			neg_s1 <= a[63] ^ b[63];
			prod_s2 <= {64'd0, ll_s1} + ({64'd0, lh_s1} << 32) + ({64'd0, hl_s1} << 32)
				+ {hh_s1, 64'd0};
			neg_s2 <= neg_s1;
			if (sh[127:64] != '0) p <= neg_s2 ? S64_MIN : S64_MAX;
			else p <= from_mag(neg_s2, sh[63:0]);
		end
	end
endmodule
`default_nettype wire

### hdl/lcf_divlane.sv
`default_nettype none
// Pipelined restoring divider lane: one quotient bit per stage over the
// 32+FRAC_BITS bit dividend (|slip| << F). Output is the signed creepage.
module lcf_divlane #(
	parameter int FRAC_BITS = lcf_pkg::FRAC_BITS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      en,
	input  wire logic signed [31:0]        slip,
	input  wire logic [31:0]               divisor,
	output logic signed [63:0]             creep
);
	import lcf_pkg::*;
	localparam int NW = 32 + FRAC_BITS;
	localparam int NS = NW;

	logic [NW-1:0] num_s [NS+1];
	logic [NW-1:0] quo_s [NS+1];
	logic [32:0]   rem_s [NS+1];
	logic [31:0]   den_s [NS+1];
	logic          neg_s [NS+1];

	always_comb begin
		num_s[0] = NW'(mag_of(64'(slip))) << FRAC_BITS;
		quo_s[0] = '0;
		rem_s[0] = '0;
		den_s[0] = divisor;
		neg_s[0] = slip[31];
	end

	for (genvar i = 0; i < NS; i++) begin : g_st
		logic [33:0] trial;
		always_comb trial = {rem_s[i], num_s[i][NW-1]} - {2'b0, den_s[i]};
		always_ff @(posedge clk) begin
			if (en) begin
				num_s[i+1] <= num_s[i] << 1;
				den_s[i+1] <= den_s[i];
				neg_s[i+1] <= neg_s[i];
				if (!trial[33]) begin
					rem_s[i+1] <= trial[32:0];
					quo_s[i+1] <= {quo_s[i][NW-2:0], 1'b1};
				end else begin
					rem_s[i+1] <= {rem_s[i][31:0], num_s[i][NW-1]};
					quo_s[i+1] <= {quo_s[i][NW-2:0], 1'b0};
				end
			end
		end
	end

	always_comb creep = from_mag(neg_s[NS], 64'(quo_s[NS]));
endmodule
`default_nettype wire

### hdl/lcf_cfg.sv
`default_nettype none
// Configuration registers and derived values a*b>>F, and floor(sqrt(a*b))
// computed by an iterative unit after each write to a or b, which restarts it.
module lcf_cfg #(
	parameter int FRAC_BITS = lcf_pkg::FRAC_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [lcf_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  wire logic [lcf_pkg::CFG_DATA_W-1:0]      cfg_data,
	output logic [62:0]                              shear_q,
	output logic [31:0]                              c11_q,
	output logic [31:0]                              c22_q,
	output logic [31:0]                              c23_q,
	output logic [31:0]                              c33_q,
	output logic [31:0]                              min_q,
	output logic [63:0]                              ab_q,
	output logic [63:0]                              rt_q
);
	import lcf_pkg::*;
	logic [31:0] a_q, b_q;
	logic [63:0] prod_q, v_q, bit_q;
	logic [5:0]  cnt_q;
	logic        busy_q, start_q;
	logic [63:0] rb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q <= 32'(6 << FRAC_BITS);
			b_q <= 32'(5 << FRAC_BITS);
			shear_q <= '0;
			c11_q <= '0; c22_q <= '0; c23_q <= '0; c33_q <= '0;
			min_q <= 32'(((64'd5 << FRAC_BITS) + 64'd500) / 64'd1000);
			start_q <= 1'b1;
		end else begin
			start_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_SEMI_LONG: begin a_q <= cfg_data[31:0]; start_q <= 1'b1; end
					REG_SEMI_LAT:  begin b_q <= cfg_data[31:0]; start_q <= 1'b1; end
					REG_SHEAR:     shear_q <= cfg_data;
					REG_C11:       c11_q <= cfg_data[31:0];
					REG_C22:       c22_q <= cfg_data[31:0];
					REG_C23:       c23_q <= cfg_data[31:0];
					REG_C33:       c33_q <= cfg_data[31:0];
					REG_MIN_SPEED: min_q <= cfg_data[31:0];
					default: ;
				endcase
			end
		end
	end

	always_comb rb = rt_q + bit_q;

	// Square root runs 32 steps; configuration must settle before items flow, which the block itself does not enforce.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start_q) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 6'd1;
			if (cnt_q == 6'd32) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start_q) begin
			prod_q <= 64'(a_q) * 64'(b_q);
			rt_q <= '0;
			bit_q <= 64'd1 << 62;
			v_q <= '0;
		end else if (busy_q) begin
			if (cnt_q == 6'd0) begin
				v_q <= prod_q;
				ab_q <= prod_q >> FRAC_BITS;
			end else if (v_q >= rb) begin
				v_q <= v_q - rb;
				rt_q <= (rt_q >> 1) + bit_q;
				bit_q <= bit_q >> 2;
			end else begin
				rt_q <= rt_q >> 1;
				bit_q <= bit_q >> 2;
			end
		end
	end
endmodule
`default_nettype wire

### tb/linear_creep_force_top_test.sv
`timescale 1ns / 1ps
`default_nettype none
module linear_creep_force_top_test;
	import lcf_pkg::*;

	localparam int FB = FRAC_BITS_DEF;
	localparam int DRAIN_CYCLES = 90;
	localparam int SQRT_SETTLE = 40;
	localparam int STALL_LIMIT = 5000;

	class creep_scoreboard;
		logic [31:0] axis_a, axis_b, c11, c22, c23, c33, vmin;
		logic [62:0] shear;
		out_item_t force_q[$];
		int mismatches;
		int checked;

		function void reset_regs();
			axis_a = 32'(6) << FB;
			axis_b = 32'(5) << FB;
			shear = '0;
			c11 = '0;
			c22 = '0;
			c23 = '0;
			c33 = '0;
			vmin = 32'(((64'd5 << FB) + 64'd500) / 64'd1000);
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_SEMI_LONG: axis_a = val[31:0];
				REG_SEMI_LAT:  axis_b = val[31:0];
				REG_SHEAR:     shear = val;
				REG_C11:       c11 = val[31:0];
				REG_C22:       c22 = val[31:0];
				REG_C23:       c23 = val[31:0];
				REG_C33:       c33 = val[31:0];
				REG_MIN_SPEED: vmin = val[31:0];
				default: ;
			endcase
		endfunction

		function logic [63:0] abs64(logic signed [63:0] x);
			return x[63] ? 64'(-x) : 64'(x);
		endfunction

		function logic signed [63:0] signed_sat(logic neg, logic [63:0] m);
			if (!neg) return m[63] ? S64_MAX : $signed(m);
			if (m[63]) return S64_MIN;
			return -$signed(m);
		endfunction

		function logic signed [63:0] fmul(logic signed [63:0] x, logic signed [63:0] y);
			logic [127:0] p;
			p = ({64'd0, abs64(x)} * {64'd0, abs64(y)}) >> FB;
			if (p[127:64] != 0) return (x[63] ^ y[63]) ? S64_MIN : S64_MAX;
			return signed_sat(x[63] ^ y[63], p[63:0]);
		endfunction

		function logic signed [63:0] add_sat(logic signed [63:0] x, logic signed [63:0] y);
			logic signed [64:0] s;
			s = 65'(x) + 65'(y);
			if (s > 65'(S64_MAX)) return S64_MAX;
			if (s < 65'(S64_MIN)) return S64_MIN;
			return s[63:0];
		endfunction

		function logic signed [63:0] neg_sat(logic signed [63:0] x);
			return (x == S64_MIN) ? S64_MAX : -x;
		endfunction

		function logic [63:0] root64(logic [63:0] v);
			logic [63:0] r, t;
			r = 0;
			for (int b = 31; b >= 0; b--) begin
				t = r | (64'd1 << b);
				if (t * t <= v) r = t;
			end
			return r;
		endfunction

		function logic signed [63:0] creepage(logic signed [31:0] slip, logic [63:0] spd);
			logic [63:0] m;
			m = (abs64(64'(slip)) << FB) / spd;
			return signed_sat(slip[31], m);
		endfunction

		function void note_input(in_item_t it);
			out_item_t e;
			logic [63:0] spd, prod, ab, rt;
			logic signed [63:0] gab, cx, cy, cp, k23, k33, fx, fy, mz;
			e = '0;
			spd = abs64(64'(it.ref_speed));
			if (spd != 0) begin
				if (spd <= {32'd0, vmin}) spd = {32'd0, vmin};
				prod = {32'd0, axis_a} * {32'd0, axis_b};
				ab = prod >> FB;
				rt = root64(prod);
				gab = fmul({1'b0, shear}, ab);
				cx = creepage(it.slip_long, spd);
				cy = creepage(it.slip_lat, spd);
				cp = creepage(it.slip_spin, spd);
				k23 = fmul(rt, {32'd0, c23});
				k33 = fmul(ab, {32'd0, c33});
				fx = fmul({32'd0, c11}, cx);
				fy = add_sat(fmul({32'd0, c22}, cy), fmul(k23, cp));
				mz = add_sat(neg_sat(fmul(k23, cy)), fmul(k33, cp));
				e.force_long = neg_sat(fmul(gab, fx));
				e.force_lat = neg_sat(fmul(gab, fy));
				e.spin_moment = neg_sat(fmul(gab, mz));
				e.used_speed = spd[31:0];
			end
			force_q.push_back(e);
		endfunction

		function void report(string fld, logic [63:0] exp_v, logic [63:0] got_v);
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch on %s: expected %h, got %h", fld, exp_v, got_v);
		endfunction

		function void check_result(out_item_t got);
			out_item_t e;
			if (force_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result transfer: %p", got);
				return;
			end
			e = force_q.pop_front();
			checked++;
			if (got.force_long !== e.force_long) report("force_long", e.force_long, got.force_long);
			if (got.force_lat !== e.force_lat) report("force_lat", e.force_lat, got.force_lat);
			if (got.spin_moment !== e.spin_moment)
				report("spin_moment", e.spin_moment, got.spin_moment);
			if (got.used_speed !== e.used_speed)
				report("used_speed", 64'(e.used_speed), 64'(got.used_speed));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	lcf_stream_if #(.T(in_item_t)) in_ch ();
	lcf_stream_if #(.T(out_item_t)) out_ch ();

	linear_creep_force_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	creep_scoreboard sb;
	bit tx_gaps;
	bit rx_stalls;
	int rx_hold;
	int idle_count;
	int sent;
	int cfg_sets;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Monitor: both channels are sampled at the rising edge.
	always @(posedge clk) begin
		bit moved;
		moved = 1'b0;
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) begin
				sb.note_input(in_ch.data);
				moved = 1'b1;
			end
			if (out_ch.valid && out_ch.ready) begin
				sb.check_result(out_ch.data);
				moved = 1'b1;
			end
			idle_count <= moved ? 0 : idle_count + 1;
			if (idle_count >= STALL_LIMIT) begin
				$display("FAIL linear_creep_force_top");
				$finish;
			end
		end
	end

	// Result side: random ready bursts, or a long hold-off on request.
	initial begin
		int n;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				out_ch.ready = 1'b0;
				repeat (rx_hold) @(negedge clk);
				rx_hold = 0;
			end
			n = $urandom_range(1, 6);
			out_ch.ready = !(rx_stalls && ($urandom_range(0, 2) == 0));
			repeat (n - 1) @(negedge clk);
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_data = val;
		sb.write_reg(idx, val);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic wait_drained();
		while (sb.force_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic load_regs(logic [31:0] a, logic [31:0] b, logic [62:0] g,
			logic [31:0] k11, logic [31:0] k22, logic [31:0] k23, logic [31:0] k33,
			logic [31:0] vm);
		wait_drained();
		write_reg(REG_SEMI_LONG, 63'(a));
		write_reg(REG_SEMI_LAT, 63'(b));
		write_reg(REG_SHEAR, g);
		write_reg(REG_C11, 63'(k11));
		write_reg(REG_C22, 63'(k22));
		write_reg(REG_C23, 63'(k23));
		write_reg(REG_C33, 63'(k33));
		write_reg(REG_MIN_SPEED, 63'(vm));
		cfg_sets++;
		// The block derives the square root of a*b iteratively.
		repeat (SQRT_SETTLE) @(negedge clk);
	endtask

	task automatic send_item(in_item_t it);
		int gap;
		if (tx_gaps && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 6);
			in_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.data = it;
		do @(posedge clk); while (!in_ch.ready);
		@(negedge clk);
		in_ch.valid = 1'b0;
		sent++;
	endtask

	function automatic logic [31:0] rand_word();
		logic [31:0] w;
		w = $urandom;
		case ($urandom_range(0, 3))
			0: return w;
			1: return w >> $urandom_range(0, 31);
			2: return $signed(w) >>> $urandom_range(8, 31);
			default: return w >> $urandom_range(20, 31);
		endcase
	endfunction

	function automatic logic [31:0] rand_speed();
		case ($urandom_range(0, 7))
			0: return 32'd0;
			1: return 32'h8000_0000;
			2: return $urandom_range(0, 2) == 0 ? sb.vmin : $urandom_range(1, 90000);
			3: return -$urandom_range(1, 90000);
			default: return rand_word();
		endcase
	endfunction

	function automatic in_item_t rand_item();
		in_item_t it;
		it.slip_long = rand_word();
		it.slip_lat = rand_word();
		it.slip_spin = rand_word();
		it.ref_speed = rand_speed();
		return it;
	endfunction

	function automatic logic [62:0] rand_reg63();
		return {$urandom, $urandom} >> (1 + $urandom_range(0, 62));
	endfunction

	task automatic random_regs();
		load_regs(rand_word(), rand_word(), rand_reg63(), rand_word(), rand_word(),
			rand_word(), rand_word(), $urandom_range(0, 3) == 0 ? 32'd0 : rand_word());
	endtask

	task automatic random_burst(int count);
		for (int i = 0; i < count; i++) begin
			// Halfway through the burst the sender waits until every result is back.
			if (i == count / 2)
				while (sb.force_q.size() != 0) @(negedge clk);
			send_item(rand_item());
		end
	endtask

	initial begin
		in_item_t it;
		logic [31:0] dir_slip[6];
		sb = new();
		sb.reset_regs();
		sb.mismatches = 0;
		sb.checked = 0;
		idle_count = 0;
		sent = 0;
		cfg_sets = 0;
		rx_hold = 0;
		tx_gaps = 1'b1;
		rx_stalls = 1'b1;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Two items with the reset values, where G is zero.
		send_item('{32'sh0100_0000, -32'sh0080_0000, 32'sh0001_0000, 32'sh0400_0000});
		send_item('{32'sh0100_0000, 32'sh0100_0000, 32'sh0100_0000, 32'sh0000_0000});

		// Realistic contact, then the extreme values of every field.
		load_regs(32'h0300_0000, 32'h0200_0000, 63'(64'd1000 << FB), 32'h0400_0000,
			32'h0380_0000, 32'h0180_0000, 32'h0100_0000, sb.vmin);
		dir_slip = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0000_0001, 32'hFFFF_FFFF,
			32'h0010_0000};
		foreach (dir_slip[i]) begin
			it = '{dir_slip[i], dir_slip[(i + 1) % 6], dir_slip[(i + 2) % 6], 32'sh0200_0000};
			send_item(it);
		end
		send_item('{32'sh0100_0000, 32'sh0100_0000, 32'sh0100_0000, 32'sh0000_0000});
		send_item('{32'sh0100_0000, 32'sh0100_0000, 32'sh0100_0000, 32'sh0000_0001});
		send_item('{32'sh0100_0000, -32'sh0100_0000, 32'sh0100_0000, -32'sh0000_0001});
		send_item('{32'sh0100_0000, 32'sh0100_0000, 32'sh0100_0000, $signed(sb.vmin)});
		send_item('{32'sh0100_0000, 32'sh0100_0000, 32'sh0100_0000, $signed(sb.vmin + 1)});
		send_item('{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000});
		send_item('{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF});

		// Every register at its largest value; the larger slips drive the outputs to saturation.
		load_regs('1, '1, '1, '1, '1, '1, '1, '1);
		send_item('{32'sh0100_0000, -32'sh0100_0000, 32'sh0100_0000, 32'sh0100_0000});
		send_item('{32'sh8000_0000, 32'sh7FFF_FFFF, -32'sh1, 32'sh0000_0005});
		send_item('{32'sh0000_0001, 32'sh0000_0001, 32'sh0000_0001, 32'sh7FFF_FFFF});

		// No clamp: the raw speed is the divisor.
		load_regs(32'h0100_0000, 32'h0100_0000, 63'(64'd1 << FB), 32'h0100_0000,
			32'h0100_0000, 32'h0100_0000, 32'h0100_0000, 32'd0);
		send_item('{32'sh0100_0000, 32'sh0100_0000, 32'sh0100_0000, 32'sh0000_0001});
		send_item('{-32'sh0100_0000, 32'sh0000_0003, 32'sh0100_0000, 32'sh0000_0002});
		send_item('{32'sh0, 32'sh0, 32'sh0, 32'sh0});

		// All zero registers.
		load_regs('0, '0, '0, '0, '0, '0, '0, '0);
		random_burst(30);

		random_regs();
		random_burst(100);

		// Long hold-off on the result side while items keep coming.
		random_regs();
		rx_hold = 300;
		random_burst(100);

		random_regs();
		random_burst(100);

		load_regs(32'h0300_0000, 32'h0200_0000, 63'(64'd50 << FB), 32'h0400_0000,
			32'h0380_0000, 32'h0180_0000, 32'h0100_0000, 32'd83886);
		random_burst(100);

		// Final stretch at full rate on both sides.
		random_regs();
		tx_gaps = 1'b0;
		rx_stalls = 1'b0;
		random_burst(100);

		while (sb.force_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d input transfers and %0d result transfers over %0d register sets,",
			sent, sb.checked, cfg_sets);
		$display("including zero, clamped and most negative speeds and saturating settings.");
		if (sb.mismatches == 0 && sb.force_q.size() == 0) begin
			$display("PASS linear_creep_force_top");
		end else begin
			$display("%0d mismatches, %0d results missing", sb.mismatches, sb.force_q.size());
			$display("FAIL linear_creep_force_top");
		end
		$finish;
	end
endmodule
`default_nettype wire
